>>> rtl/agent_order_position_tracker_defines.svh
// Assertion macros shared by the order tracker RTL.
// Included by files that carry concurrent checks; no other content.
`ifndef AGENT_ORDER_POSITION_TRACKER_DEFINES_SVH
`define AGENT_ORDER_POSITION_TRACKER_DEFINES_SVH

// Implication checked every edge outside reset.
`define AOPT_ASSERT_IMP(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");

// Next-cycle implication.
`define AOPT_ASSERT_NXT(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");

`endif

>>> rtl/aopt_pkg.sv
// Package for the order tracker: opcodes, status codes, sequencer states.
// No dependencies.
`timescale 1ns / 1ps
package aopt_pkg;
    localparam int AgentCountDef = 16;
    localparam int OrdersPerAgentDef = 16;

    localparam logic [2:0] OP_ACCEPT = 3'd0;
    localparam logic [2:0] OP_CANCEL = 3'd1;
    localparam logic [2:0] OP_TRADE  = 3'd2;
    localparam logic [2:0] OP_REJECT = 3'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_NOTFOUND = 2'd2;

    localparam logic signed [47:0] POS_MAX = {1'b0, {47{1'b1}}};
    localparam logic signed [47:0] POS_MIN = {1'b1, {47{1'b0}}};

    typedef enum logic [2:0] {
        S_IDLE, S_SCAN, S_DECIDE, S_UPDATE, S_LOOK, S_OUT
    } t_state;
endpackage

>>> rtl/aopt_ram.sv
// Generic simple dual-port RAM (one write port, one read port), registered read, write-first not assumed.
// No dependencies.
`timescale 1ns / 1ps
module aopt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

>>> rtl/agent_order_position_tracker.sv
// Order tracker top: sequencer, slot-scan compare unit, slot and agent memories.
// Depends on aopt_pkg, aopt_ram and the assertion macro header.
//
// Usage: one event beat enters on the i_ valid/stall input channel whenever
// o_in_stall is low; one result beat leaves on the o_ output channel.
// The block handles one event at a time. A slot scan reads one slot of the
// agent each cycle through the shared key compare, then a decide state
// updates the slot memories and valid bits, an update state clears the scan
// counters, a second scan reports the order after the event, and an output
// state loads the result; the event rate is set by the two slot scans
// through the one shared read address of the slot memories.
// An out-of-range agent skips the scans and goes straight to the output state.
// Reset (synchronous, active low) clears all slot valid bits and the agent
// inventory and time registers at once; slot payload memories are not
// cleared, they are only read under a valid bit.
// While the receiver holds i_out_stall the result holds; the next event is
// still taken and worked, then waits in the output cycle until the held
// beat leaves, and no further event is taken meanwhile.
`timescale 1ns / 1ps
`include "agent_order_position_tracker_defines.svh"
module agent_order_position_tracker
    import aopt_pkg::*;
#(
    parameter int AGENT_COUNT = AgentCountDef,
    parameter int ORDERS_PER_AGENT = OrdersPerAgentDef
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [2:0]         i_opcode,
    input  logic [3:0]         i_agent,
    input  logic [31:0]        i_order_key,
    input  logic [7:0]         i_symbol_code,
    input  logic               i_side_bid,
    input  logic [31:0]        i_limit_price,
    input  logic signed [31:0] i_qty,
    input  logic [47:0]        i_event_time,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [1:0]         o_status,
    output logic               o_order_found,
    output logic [30:0]        o_found_remaining,
    output logic [31:0]        o_found_price,
    output logic               o_found_side,
    output logic signed [47:0] o_position,
    output logic [4:0]         o_open_count,
    output logic [47:0]        o_fill_time,
    output logic [47:0]        o_action_time
);
    localparam int SW = (ORDERS_PER_AGENT > 1) ? $clog2(ORDERS_PER_AGENT) : 1;
    localparam int AW = (AGENT_COUNT > 1) ? $clog2(AGENT_COUNT) : 1;
    localparam int TOT = AGENT_COUNT * ORDERS_PER_AGENT;
    localparam int TW = (TOT > 1) ? $clog2(TOT) : 1;
    localparam int CW = $clog2(ORDERS_PER_AGENT + 1);

    t_state r_state, n_state;

    // latched event
    logic [2:0]         r_op;
    logic [AW-1:0]      r_agent;
    logic               r_agent_ok;
    logic [31:0]        r_key;
    logic [7:0]         r_sym;
    logic               r_bid;
    logic [31:0]        r_price;
    logic signed [31:0] r_qty;
    logic [47:0]        r_time;

    // scan counters
    logic [SW:0] r_ridx;   // read address counter
    logic [SW:0] r_cidx;   // compare index (one behind)
    logic        r_cmp_en;
    logic        r_hit;
    logic [SW-1:0] r_hit_idx;
    logic [30:0] r_hit_rem;
    logic [31:0] r_hit_price;
    logic        r_hit_side;

    logic [TOT-1:0] r_valid;
    logic signed [47:0] r_inv [AGENT_COUNT];
    logic [47:0] r_ftime [AGENT_COUNT];
    logic [47:0] r_atime [AGENT_COUNT];

    // output beat
    logic        r_ovalid;
    logic [1:0]  r_status;
    logic [1:0]  r_ostatus;
    logic        r_ofound;
    logic [30:0] r_orem;
    logic [31:0] r_oprice;
    logic        r_oside;
    logic signed [47:0] r_opos;
    logic [4:0]  r_ocnt;
    logic [47:0] r_oft;
    logic [47:0] r_oat;

    // memory ports
    logic           w_we;
    logic [TW-1:0]  w_waddr;
    logic [TW-1:0]  w_raddr;
    logic [31:0]    w_rkey;
    logic [31:0]    w_rprice;
    logic [30:0]    w_rrem;
    logic           w_rside;
    logic [30:0]    w_wrem;
    logic [31:0]    w_wkey;
    logic [31:0]    w_wprice;
    logic           w_wside;
    logic [7:0]     w_rsym;
    logic [47:0]    w_rtime;
    logic           w_full_write;

    logic [TW-1:0] w_base;
    assign w_base = TW'(r_agent) * TW'(ORDERS_PER_AGENT);
    assign w_raddr = w_base + TW'(r_ridx[SW-1:0]);

    aopt_ram #(.WIDTH(32), .DEPTH(TOT)) u_key (
        .i_clk(i_clk), .i_we(w_we && w_full_write), .i_waddr(w_waddr),
        .i_wdata(w_wkey), .i_raddr(w_raddr), .o_rdata(w_rkey));
    aopt_ram #(.WIDTH(32), .DEPTH(TOT)) u_price (
        .i_clk(i_clk), .i_we(w_we && w_full_write), .i_waddr(w_waddr),
        .i_wdata(w_wprice), .i_raddr(w_raddr), .o_rdata(w_rprice));
    aopt_ram #(.WIDTH(1), .DEPTH(TOT)) u_side (
        .i_clk(i_clk), .i_we(w_we && w_full_write), .i_waddr(w_waddr),
        .i_wdata(w_wside), .i_raddr(w_raddr), .o_rdata(w_rside));
    aopt_ram #(.WIDTH(8), .DEPTH(TOT)) u_sym (
        .i_clk(i_clk), .i_we(w_we && w_full_write), .i_waddr(w_waddr),
        .i_wdata(r_sym), .i_raddr(w_raddr), .o_rdata(w_rsym));
    aopt_ram #(.WIDTH(48), .DEPTH(TOT)) u_time (
        .i_clk(i_clk), .i_we(w_we && w_full_write), .i_waddr(w_waddr),
        .i_wdata(r_time), .i_raddr(w_raddr), .o_rdata(w_rtime));
    aopt_ram #(.WIDTH(31), .DEPTH(TOT)) u_rem (
        .i_clk(i_clk), .i_we(w_we), .i_waddr(w_waddr),
        .i_wdata(w_wrem), .i_raddr(w_raddr), .o_rdata(w_rrem));

    assign w_wkey = r_key;
    assign w_wprice = r_price;
    assign w_wside = r_bid;

    // decide: pick target slot and new remaining
    logic [SW-1:0] w_free_idx;
    logic          w_free_ok;
    logic [ORDERS_PER_AGENT-1:0] w_avalid;
    assign w_avalid = r_valid[w_base +: ORDERS_PER_AGENT];

    always_comb begin
        w_free_idx = '0;
        w_free_ok = 1'b0;
        for (int k = ORDERS_PER_AGENT - 1; k >= 0; k--) begin
            if (!w_avalid[k]) begin
                w_free_idx = SW'(k);
                w_free_ok = 1'b1;
            end
        end
    end

    // trade remaining: rem - qty, clamp to [0, 2^31-1]
    logic signed [33:0] w_rdiff;
    logic [30:0]        w_trem;
    assign w_rdiff = $signed({3'b000, r_hit_rem}) - 34'(r_qty);
    always_comb begin
        if (w_rdiff < 0) begin
            w_trem = '0;
        end else if (w_rdiff > 34'sh7FFFFFFF) begin
            w_trem = '1;
        end else begin
            w_trem = w_rdiff[30:0];
        end
    end

    logic w_is_acc, w_is_can, w_is_trd;
    assign w_is_acc = (r_op == OP_ACCEPT) && (r_qty > 0);
    assign w_is_can = (r_op == OP_CANCEL);
    assign w_is_trd = (r_op == OP_TRADE);

    always_comb begin
        w_we = 1'b0;
        w_full_write = 1'b0;
        w_waddr = w_base + TW'(r_hit_idx);
        w_wrem = w_trem;
        if (r_state == S_DECIDE) begin
            if (w_is_acc) begin
                w_full_write = 1'b1;
                w_wrem = r_qty[30:0];
                if (r_hit) begin
                    w_we = 1'b1;
                end else if (w_free_ok) begin
                    w_we = 1'b1;
                    w_waddr = w_base + TW'(w_free_idx);
                end
            end else if (w_is_trd && r_hit) begin
                w_we = 1'b1;
            end
        end
    end

    // inventory saturating add of the signed quantity, negated for the ask side
    logic signed [48:0] w_inv_sum;
    logic signed [47:0] w_inv_new;
    assign w_inv_sum = 49'(r_inv[r_agent]) + (r_bid ? 49'(r_qty) : -49'(r_qty));
    always_comb begin
        if (w_inv_sum > 49'(POS_MAX)) begin
            w_inv_new = POS_MAX;
        end else if (w_inv_sum < 49'(POS_MIN)) begin
            w_inv_new = POS_MIN;
        end else begin
            w_inv_new = w_inv_sum[47:0];
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (i_in_valid && !o_in_stall) n_state =
                (32'(i_agent) < AGENT_COUNT) ? S_SCAN : S_OUT;
            S_SCAN: if (r_cmp_en && r_cidx == (SW + 1)'(ORDERS_PER_AGENT - 1))
                n_state = S_DECIDE;
            S_DECIDE: n_state = S_UPDATE;
            S_UPDATE: n_state = S_LOOK;
            S_LOOK: if (r_cmp_en && r_cidx == (SW + 1)'(ORDERS_PER_AGENT - 1))
                n_state = S_OUT;
            S_OUT: if (!r_ovalid || !i_out_stall) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // a held result waits in the output register; work on the next event goes on
    assign o_in_stall = (r_state != S_IDLE);

    logic w_scanning;
    assign w_scanning = (r_state == S_SCAN) || (r_state == S_LOOK);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= '0;
            r_ovalid <= 1'b0;
            r_cmp_en <= 1'b0;
            r_ridx <= '0;
            r_cidx <= '0;
            r_hit <= 1'b0;
            for (int g = 0; g < AGENT_COUNT; g++) begin
                r_inv[g] <= '0;
                r_ftime[g] <= '0;
                r_atime[g] <= '0;
            end
        end else begin
            r_state <= r_state == S_OUT && r_ovalid && i_out_stall ? S_OUT : n_state;
            // output state reloads the beat itself
            if (r_ovalid && !i_out_stall && r_state != S_OUT) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid && !o_in_stall) begin
                        r_op <= i_opcode;
                        r_agent <= AW'(i_agent);
                        r_agent_ok <= 32'(i_agent) < AGENT_COUNT;
                        r_key <= i_order_key;
                        r_sym <= i_symbol_code;
                        r_bid <= i_side_bid;
                        r_price <= i_limit_price;
                        r_qty <= i_qty;
                        r_time <= i_event_time;
                        r_ridx <= '0;
                        r_cmp_en <= 1'b0;
                        r_hit <= 1'b0;
                    end
                end
                S_DECIDE: begin
                    r_status <= ST_OK;
                    if (r_op == OP_ACCEPT) begin
                        r_atime[r_agent] <= r_time;
                        if (w_is_acc) begin
                            if (r_hit) begin
                                r_valid[w_base + TW'(r_hit_idx)] <= 1'b1;
                            end else if (w_free_ok) begin
                                r_valid[w_base + TW'(w_free_idx)] <= 1'b1;
                            end else begin
                                r_status <= ST_FULL;
                            end
                        end
                    end else if (w_is_can) begin
                        r_atime[r_agent] <= r_time;
                        if (r_hit) begin
                            r_valid[w_base + TW'(r_hit_idx)] <= 1'b0;
                        end else begin
                            r_status <= ST_NOTFOUND;
                        end
                    end else if (w_is_trd) begin
                        r_atime[r_agent] <= r_time;
                        r_ftime[r_agent] <= r_time;
                        r_inv[r_agent] <= w_inv_new;
                        if (r_hit) begin
                            if (w_trem == '0) begin
                                r_valid[w_base + TW'(r_hit_idx)] <= 1'b0;
                            end
                        end else begin
                            r_status <= ST_NOTFOUND;
                        end
                    end else if (r_op == OP_REJECT) begin
                        r_atime[r_agent] <= r_time;
                    end
                end
                S_UPDATE: begin
                    r_ridx <= '0;
                    r_cmp_en <= 1'b0;
                    r_hit <= 1'b0;
                end
                S_OUT: begin
                    if (!r_ovalid || !i_out_stall) begin
                        r_ovalid <= 1'b1;
                        r_ofound <= 1'b0;
                        r_orem <= '0;
                        r_oprice <= '0;
                        r_oside <= 1'b0;
                        if (!r_agent_ok) begin
                            r_ostatus <= ST_NOTFOUND;
                            r_opos <= '0;
                            r_ocnt <= '0;
                            r_oft <= '0;
                            r_oat <= '0;
                        end else begin
                            r_ostatus <= (r_op > OP_REJECT && !r_hit) ? ST_NOTFOUND
                                : r_status;
                            if (r_hit) begin
                                r_ofound <= 1'b1;
                                r_orem <= r_hit_rem;
                                r_oprice <= r_hit_price;
                                r_oside <= r_hit_side;
                            end
                            r_opos <= r_inv[r_agent];
                            r_ocnt <= 5'($countones(w_avalid));
                            r_oft <= r_ftime[r_agent];
                            r_oat <= r_atime[r_agent];
                        end
                    end
                end
                default: ;
            endcase
            // shared scan: one read issued and one compare done per cycle
            if (w_scanning) begin
                if (r_ridx < (SW + 1)'(ORDERS_PER_AGENT)) begin
                    r_ridx <= r_ridx + 1'b1;
                end
                r_cmp_en <= r_ridx < (SW + 1)'(ORDERS_PER_AGENT);
                r_cidx <= r_ridx;
                if (r_cmp_en && !r_hit && w_avalid[r_cidx[SW-1:0]]
                    && w_rkey == r_key) begin
                    r_hit <= 1'b1;
                    r_hit_idx <= r_cidx[SW-1:0];
                    r_hit_rem <= w_rrem;
                    r_hit_price <= w_rprice;
                    r_hit_side <= w_rside;
                end
            end
        end
    end

    assign o_out_valid = r_ovalid;
    assign o_status = r_ostatus;
    assign o_order_found = r_ofound;
    assign o_found_remaining = r_orem;
    assign o_found_price = r_oprice;
    assign o_found_side = r_oside;
    assign o_position = r_opos;
    assign o_open_count = r_ocnt;
    assign o_fill_time = r_oft;
    assign o_action_time = r_oat;

    // symbol and accept time are stored only; keep reads observed
    logic w_unused;
    assign w_unused = ^{w_rsym, w_rtime, CW'(0)};

    `AOPT_ASSERT_IMP(a_busy_stall, i_clk, i_rst_n, r_state != S_IDLE, o_in_stall)
    `AOPT_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, r_ovalid && i_out_stall,
        r_ovalid && $stable(r_ostatus))
    `AOPT_ASSERT_IMP(a_found_zero, i_clk, i_rst_n, r_ovalid && !r_ofound,
        r_orem == '0 && r_oprice == '0)
    `AOPT_ASSERT_IMP(a_cnt_max, i_clk, i_rst_n, r_ovalid,
        32'(r_ocnt) <= ORDERS_PER_AGENT)
endmodule
